// File: rtl/core/pfc_pkg.sv
package pfc_pkg;

	// Default table shape
	localparam int ROWS_DEF = 3;
	localparam int COLS_DEF = 11;

	// Symbol and table storage
	localparam int SYM_W          = 8;
	localparam int CELLS_PER_WORD = 8;
	localparam int NUM_WORDS      = 5;
	localparam int WORD_W         = SYM_W * CELLS_PER_WORD;

	// Configuration port
	localparam int APB_DATA_W = 64;
	localparam int APB_ADDR_W = $clog2(8 * NUM_WORDS);
	localparam int REG_IDX_W  = APB_ADDR_W - 3;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_TABLE_WORD_0 = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_TABLE_WORD_4 = REG_IDX_W'(4);

	// Operation codes
	localparam logic CMD_ENCRYPT = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;

endpackage

// File: rtl/core/playfair_digraph_cipher_core.sv
// Playfair digraph cipher on a ROWS x COLS table of byte symbols, loaded through
// five 64-bit APB registers (cells row-major, eight per register, cell 0 in the
// low byte). Each item carries two symbols and the operation in tuser (0 encrypt,
// 1 decrypt); each result carries the two transformed symbols and a not-found
// flag in tuser, with both symbols zero when either input symbol is missing from
// the table. The datapath is a four-stage pipeline (cell compare, position
// encode, shift and cell select, output read), so one item is taken per cycle
// while the output is not stalled. The table must only be written while no
// items are in flight.
module playfair_digraph_cipher_core #(
	parameter int ROWS = pfc_pkg::ROWS_DEF,
	parameter int COLS = pfc_pkg::COLS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// APB configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [pfc_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [pfc_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [pfc_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready,
	// Input items
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [15:0]                      s_tdata,  // second_symbol, first_symbol
	input  logic [0:0]                       s_tuser,  // cmd
	// Result items
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [15:0]                      m_tdata,  // out_second, out_first
	output logic [0:0]                       m_tuser   // not_found
);
	import pfc_pkg::*;

	localparam int NUM_CELLS = ROWS * COLS;
	localparam int ROW_W     = $clog2(ROWS);
	localparam int COL_W     = $clog2(COLS);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLS - 1);

	// Table registers
	logic [WORD_W-1:0]    table_q [NUM_WORDS];
	logic [SYM_W-1:0]     key_sym [NUM_CELLS];
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:3];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < NUM_WORDS; w++) table_q[w] <= '0;
		end else if (cfg_wr && reg_idx <= REG_TABLE_WORD_4) begin
			table_q[reg_idx] <= pwdata;
		end
	end

	// Register readback, zero beyond the list
	always_comb begin
		prdata = '0;
		if (reg_idx >= REG_TABLE_WORD_0 && reg_idx <= REG_TABLE_WORD_4) prdata = table_q[reg_idx];
	end

	// Cell view of the table
	for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
		localparam int WD = g / CELLS_PER_WORD;
		localparam int BT = g % CELLS_PER_WORD;
		assign key_sym[g] = table_q[WD][BT*SYM_W +: SYM_W];
	end

	// Stage handshake: a stage advances when it is empty or the next one advances
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4     = !v_s4 || m_tready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// Stage 1: compare both symbols against every cell
	logic [NUM_CELLS-1:0] match1_s1, match2_s1;
	logic                 cmd_s1;

	always_ff @(posedge clk) begin
		if (rdy1) begin
			for (int c = 0; c < NUM_CELLS; c++) begin
				match1_s1[c] <= (key_sym[c] == s_tdata[SYM_W-1:0]);
				match2_s1[c] <= (key_sym[c] == s_tdata[2*SYM_W-1:SYM_W]);
			end
			cmd_s1 <= s_tuser[0];
		end
	end

	// Stage 2: encode matches to row and column
	logic             f1, f2;
	logic [ROW_W-1:0] r1, r2;
	logic [COL_W-1:0] c1, c2;
	logic             f1_s2, f2_s2, cmd_s2;
	logic [ROW_W-1:0] r1_s2, r2_s2;
	logic [COL_W-1:0] c1_s2, c2_s2;

	pfc_locate #(.ROWS(ROWS), .COLS(COLS)) u_loc1 (
		.match(match1_s1), .found(f1), .row(r1), .col(c1)
	);

	pfc_locate #(.ROWS(ROWS), .COLS(COLS)) u_loc2 (
		.match(match2_s1), .found(f2), .row(r2), .col(c2)
	);

	always_ff @(posedge clk) begin
		if (rdy2) begin
			f1_s2  <= f1;
			f2_s2  <= f2;
			r1_s2  <= r1;
			r2_s2  <= r2;
			c1_s2  <= c1;
			c2_s2  <= c2;
			cmd_s2 <= cmd_s1;
		end
	end

	// Stage 3: apply the digraph rule and decode target cells
	logic [ROW_W-1:0]     nr1, nr2;
	logic [COL_W-1:0]     nc1, nc2;
	logic [NUM_CELLS-1:0] sel1, sel2;
	logic [NUM_CELLS-1:0] sel1_s3, sel2_s3;
	logic                 nf_s3;

	always_comb begin
		nr1 = r1_s2;
		nr2 = r2_s2;
		nc1 = c1_s2;
		nc2 = c2_s2;
		if (r1_s2 == r2_s2) begin
			// same row: shift columns with wrap
			if (cmd_s2 == CMD_DECRYPT) begin
				nc1 = (c1_s2 == '0) ? COL_LAST : c1_s2 - COL_W'(1);
				nc2 = (c2_s2 == '0) ? COL_LAST : c2_s2 - COL_W'(1);
			end else begin
				nc1 = (c1_s2 == COL_LAST) ? '0 : c1_s2 + COL_W'(1);
				nc2 = (c2_s2 == COL_LAST) ? '0 : c2_s2 + COL_W'(1);
			end
		end else if (c1_s2 == c2_s2) begin
			// same column: shift rows with wrap
			if (cmd_s2 == CMD_DECRYPT) begin
				nr1 = (r1_s2 == '0) ? ROW_LAST : r1_s2 - ROW_W'(1);
				nr2 = (r2_s2 == '0) ? ROW_LAST : r2_s2 - ROW_W'(1);
			end else begin
				nr1 = (r1_s2 == ROW_LAST) ? '0 : r1_s2 + ROW_W'(1);
				nr2 = (r2_s2 == ROW_LAST) ? '0 : r2_s2 + ROW_W'(1);
			end
		end else begin
			// rectangle: swap rows
			nr1 = r2_s2;
			nr2 = r1_s2;
		end
		for (int r = 0; r < ROWS; r++) begin
			for (int c = 0; c < COLS; c++) begin
				sel1[r*COLS+c] = (nr1 == ROW_W'(r)) && (nc1 == COL_W'(c));
				sel2[r*COLS+c] = (nr2 == ROW_W'(r)) && (nc2 == COL_W'(c));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			sel1_s3 <= sel1;
			sel2_s3 <= sel2;
			nf_s3   <= !(f1_s2 && f2_s2);
		end
	end

	// Stage 4: read selected cells into the output register
	logic [SYM_W-1:0] rd1, rd2;
	logic [SYM_W-1:0] out1_s4, out2_s4;
	logic             nf_s4;

	always_comb begin
		rd1 = '0;
		rd2 = '0;
		for (int c = 0; c < NUM_CELLS; c++) begin
			rd1 = rd1 | (sel1_s3[c] ? key_sym[c] : '0);
			rd2 = rd2 | (sel2_s3[c] ? key_sym[c] : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			out1_s4 <= nf_s3 ? '0 : rd1;
			out2_s4 <= nf_s3 ? '0 : rd2;
			nf_s4   <= nf_s3;
		end
	end

	assign m_tvalid = v_s4;
	assign m_tdata  = {out2_s4, out1_s4};
	assign m_tuser  = nf_s4;

endmodule

// File: rtl/core/pfc_locate.sv
// Resolves a cell match vector to the row and column of the highest matching cell.
module pfc_locate #(
	parameter int ROWS = pfc_pkg::ROWS_DEF,
	parameter int COLS = pfc_pkg::COLS_DEF
) (
	input  logic [ROWS*COLS-1:0]     match,
	output logic                     found,
	output logic [$clog2(ROWS)-1:0]  row,
	output logic [$clog2(COLS)-1:0]  col
);
	import pfc_pkg::*;

	localparam int ROW_W = $clog2(ROWS);
	localparam int COL_W = $clog2(COLS);

	// Later cells override earlier ones: highest-numbered match wins
	always_comb begin
		found = |match;
		row   = '0;
		col   = '0;
		for (int r = 0; r < ROWS; r++) begin
			for (int c = 0; c < COLS; c++) begin
				if (match[r*COLS+c]) begin
					row = ROW_W'(r);
					col = COL_W'(c);
				end
			end
		end
	end

endmodule

// File: rtl/core/pfc_checker.sv
// Port-level checks on the cipher core.
module pfc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [0:0]  m_tuser
);
	import pfc_pkg::*;

	// A stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Missing symbol gives zero symbols
	a_nf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == 16'h0000)
		else $error("not_found result with nonzero symbols");

	// Input backpressure only when the pipeline is full behind a stalled output
	a_bp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output stall");

	// The input stays open while the output stays open into the next cycle
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready && s_tready |=> s_tready || !m_tready)
		else $error("input closed while output drains");

endmodule

bind playfair_digraph_cipher_core pfc_checker u_pfc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
